>>> design/tgc_pkg.sv
`timescale 1ns / 1ps

package tgc_pkg;

    // coordinate, time, duration and configuration port widths
    localparam int COORD_W     = 12;
    localparam int POINT_W     = COORD_W + 1;
    localparam int DELTA_W     = POINT_W + 1;
    localparam int TIME_IN_W   = 32;
    localparam int TIME_BITS   = 32;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 8;
    localparam int DUR_W       = 16;

    // register map
    localparam logic [CFG_INDEX_W-1:0] REG_MIRROR_OFFSET  = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SWIPE_THRESH   = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_TAP_MOVE_LIMIT = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_TAP_HOLD_LIMIT = 8'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_PAIR_WINDOW    = 8'd4;

    // register reset values
    localparam logic [COORD_W-1:0] MIRROR_OFFSET_RST  = 12'd239;
    localparam logic [COORD_W-1:0] SWIPE_THRESH_RST   = 12'd40;
    localparam logic [COORD_W-1:0] TAP_MOVE_LIMIT_RST = 12'd20;
    localparam logic [DUR_W-1:0]   TAP_HOLD_LIMIT_RST = 16'd400;
    localparam logic [DUR_W-1:0]   PAIR_WINDOW_RST    = 16'd350;

    typedef enum logic [2:0] {
        G_NONE   = 3'd0,
        G_LEFT   = 3'd1,
        G_RIGHT  = 3'd2,
        G_UP     = 3'd3,
        G_DOWN   = 3'd4,
        G_SINGLE = 3'd5,
        G_DOUBLE = 3'd6
    } gesture_t;

endpackage

>>> design/touch_gesture_classifier.sv
`timescale 1ns / 1ps
// touch gesture classifier
// s_ channel: one touch-controller poll per request (finger count, raw x/y,
// millisecond timestamp). m_ channel: exactly one result per poll with the
// gesture code, the reported point (x mirrored), pressed and tapped flags.
// cfg_ port: write enable, register index and data; a write lands on the
// clock edge where cfg_wr_en is high. indexes past the register list are
// ignored. write only while no poll is in flight.
// a poll moves from the input register, through one pass of compares and
// subtractions, into the result register once that is empty or being taken.
// throughput: one poll per cycle while m_ready is high; the gesture state is
// updated on the same edge the result is written.
// reset (aresetn low, synchronous): registers return to their defaults,
// gesture state clears, both pipeline stages empty.
// stall: while m_ready is low the result holds; one more poll is taken into
// the input register, then s_ready drops until the result is taken.
module touch_gesture_classifier #(
    parameter int TIME_BITS = tgc_pkg::TIME_BITS
) (
    input  logic                             aclk,
    input  logic                             aresetn,

    input  logic                             cfg_wr_en,
    input  logic [tgc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [tgc_pkg::CFG_DATA_W-1:0]   cfg_wdata,

    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [7:0]                       s_finger_count,
    input  logic [tgc_pkg::COORD_W-1:0]      s_raw_x,
    input  logic [tgc_pkg::COORD_W-1:0]      s_raw_y,
    input  logic [tgc_pkg::TIME_IN_W-1:0]    s_time_ms,

    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [2:0]                       m_gesture,
    output logic signed [tgc_pkg::POINT_W-1:0] m_point_x,
    output logic [tgc_pkg::COORD_W-1:0]      m_point_y,
    output logic                             m_pressed,
    output logic                             m_tapped
);

    localparam int PW = tgc_pkg::POINT_W;
    localparam int CW = tgc_pkg::COORD_W;
    localparam int DW = tgc_pkg::DELTA_W;

    // configuration registers
    logic [CW-1:0]              mirror_offset_reg;
    logic [CW-1:0]              swipe_thresh_reg;
    logic [CW-1:0]              tap_move_limit_reg;
    logic [tgc_pkg::DUR_W-1:0]  tap_hold_limit_reg;
    logic [tgc_pkg::DUR_W-1:0]  pair_window_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mirror_offset_reg  <= tgc_pkg::MIRROR_OFFSET_RST;
            swipe_thresh_reg   <= tgc_pkg::SWIPE_THRESH_RST;
            tap_move_limit_reg <= tgc_pkg::TAP_MOVE_LIMIT_RST;
            tap_hold_limit_reg <= tgc_pkg::TAP_HOLD_LIMIT_RST;
            pair_window_reg    <= tgc_pkg::PAIR_WINDOW_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                tgc_pkg::REG_MIRROR_OFFSET:  mirror_offset_reg  <= cfg_wdata[CW-1:0];
                tgc_pkg::REG_SWIPE_THRESH:   swipe_thresh_reg   <= cfg_wdata[CW-1:0];
                tgc_pkg::REG_TAP_MOVE_LIMIT: tap_move_limit_reg <= cfg_wdata[CW-1:0];
                tgc_pkg::REG_TAP_HOLD_LIMIT: tap_hold_limit_reg <= cfg_wdata;
                tgc_pkg::REG_PAIR_WINDOW:    pair_window_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // input register stage
    logic                          in_valid_reg;
    logic                          in_touch_reg;
    logic [CW-1:0]                 in_x_reg;
    logic [CW-1:0]                 in_y_reg;
    logic [tgc_pkg::TIME_IN_W-1:0] in_time_reg;
    logic                          advance;
    logic                          s_fire;

    assign advance = in_valid_reg && (!m_valid || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign s_fire  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_fire) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_touch_reg <= |s_finger_count;
            in_x_reg     <= s_raw_x;
            in_y_reg     <= s_raw_y;
            in_time_reg  <= s_time_ms;
        end
    end

    // gesture state
    logic                          was_touching_reg, was_touching_next;
    logic                          tap_pending_reg, tap_pending_next;
    logic signed [PW-1:0]          start_x_reg, start_x_next;
    logic [CW-1:0]                 start_y_reg, start_y_next;
    logic signed [PW-1:0]          last_x_reg, last_x_next;
    logic [CW-1:0]                 last_y_reg, last_y_next;
    logic [TIME_BITS-1:0]          touch_start_time_reg, touch_start_time_next;
    logic [TIME_BITS-1:0]          last_tap_time_reg, last_tap_time_next;

    // per-poll evaluation
    logic [TIME_BITS-1:0]          now;
    logic signed [PW-1:0]          cur_x;
    logic [TIME_BITS-1:0]          duration;
    logic [TIME_BITS-1:0]          tap_gap;
    logic signed [DW-1:0]          dx, dy;
    logic [DW-1:0]                 adx, ady;
    logic                          tap_window_open;
    tgc_pkg::gesture_t             gesture_next;
    logic                          pressed_next;
    logic                          tapped_next;

    always_comb begin
        // timestamp bits above the input width read as zero
        for (int i = 0; i < TIME_BITS; i++) begin
            now[i] = (i < tgc_pkg::TIME_IN_W) ? in_time_reg[i] : 1'b0;
        end
        cur_x    = $signed({1'b0, mirror_offset_reg}) - $signed({1'b0, in_x_reg});
        duration = now - touch_start_time_reg;
        tap_gap  = now - last_tap_time_reg;
        dx       = DW'(last_x_reg) - DW'(start_x_reg);
        dy       = DW'($signed({1'b0, last_y_reg})) - DW'($signed({1'b0, start_y_reg}));
        adx      = dx[DW-1] ? DW'(-dx) : DW'(dx);
        ady      = dy[DW-1] ? DW'(-dy) : DW'(dy);
        tap_window_open = tap_gap < TIME_BITS'(pair_window_reg);

        was_touching_next     = in_touch_reg;
        tap_pending_next      = tap_pending_reg;
        start_x_next          = start_x_reg;
        start_y_next          = start_y_reg;
        last_x_next           = last_x_reg;
        last_y_next           = last_y_reg;
        touch_start_time_next = touch_start_time_reg;
        last_tap_time_next    = last_tap_time_reg;
        gesture_next          = tgc_pkg::G_NONE;
        pressed_next          = 1'b0;
        tapped_next           = 1'b0;

        if (in_touch_reg) begin
            last_x_next  = cur_x;
            last_y_next  = in_y_reg;
            pressed_next = 1'b1;
            if (!was_touching_reg) begin
                start_x_next          = cur_x;
                start_y_next          = in_y_reg;
                touch_start_time_next = now;
            end
        end else if (was_touching_reg) begin
            // release: classify the finished stroke
            if (adx > DW'(swipe_thresh_reg) && adx > ady) begin
                gesture_next     = (dx > 0) ? tgc_pkg::G_RIGHT : tgc_pkg::G_LEFT;
                tap_pending_next = 1'b0;
            end else if (ady > DW'(swipe_thresh_reg) && ady > adx) begin
                gesture_next     = (dy > 0) ? tgc_pkg::G_DOWN : tgc_pkg::G_UP;
                tap_pending_next = 1'b0;
            end else if (duration < TIME_BITS'(tap_hold_limit_reg) &&
                         adx < DW'(tap_move_limit_reg) && ady < DW'(tap_move_limit_reg)) begin
                if (tap_pending_reg && tap_window_open) begin
                    gesture_next     = tgc_pkg::G_DOUBLE;
                    tap_pending_next = 1'b0;
                end else begin
                    tap_pending_next   = 1'b1;
                    last_tap_time_next = now;
                    last_x_next        = start_x_reg;
                    last_y_next        = start_y_reg;
                    pressed_next       = 1'b1;
                end
            end
        end else if (tap_pending_reg && !tap_window_open) begin
            // lone tap whose window ran out
            gesture_next     = tgc_pkg::G_SINGLE;
            tapped_next      = 1'b1;
            tap_pending_next = 1'b0;
            last_x_next      = start_x_reg;
            last_y_next      = start_y_reg;
            pressed_next     = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            was_touching_reg     <= 1'b0;
            tap_pending_reg      <= 1'b0;
            start_x_reg          <= '0;
            start_y_reg          <= '0;
            last_x_reg           <= '0;
            last_y_reg           <= '0;
            touch_start_time_reg <= '0;
            last_tap_time_reg    <= '0;
        end else if (advance) begin
            was_touching_reg     <= was_touching_next;
            tap_pending_reg      <= tap_pending_next;
            start_x_reg          <= start_x_next;
            start_y_reg          <= start_y_next;
            last_x_reg           <= last_x_next;
            last_y_reg           <= last_y_next;
            touch_start_time_reg <= touch_start_time_next;
            last_tap_time_reg    <= last_tap_time_next;
        end
    end

    // result register
    logic                 m_valid_reg;
    tgc_pkg::gesture_t    gesture_reg;
    logic signed [PW-1:0] point_x_reg;
    logic [CW-1:0]        point_y_reg;
    logic                 pressed_reg;
    logic                 tapped_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            gesture_reg <= gesture_next;
            point_x_reg <= last_x_next;
            point_y_reg <= last_y_next;
            pressed_reg <= pressed_next;
            tapped_reg  <= tapped_next;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_gesture = gesture_reg;
    assign m_point_x = point_x_reg;
    assign m_point_y = point_y_reg;
    assign m_pressed = pressed_reg;
    assign m_tapped  = tapped_reg;

`ifndef SYNTHESIS
    // tapped marks exactly the single-tap result
    a_tapped_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_tapped == (m_gesture == tgc_pkg::G_SINGLE)))
        else $error("tapped flag disagrees with gesture code");

    // swipes and double taps report a released point
    a_swipe_released: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_gesture == tgc_pkg::G_LEFT || m_gesture == tgc_pkg::G_RIGHT ||
                    m_gesture == tgc_pkg::G_UP || m_gesture == tgc_pkg::G_DOWN ||
                    m_gesture == tgc_pkg::G_DOUBLE) |-> !m_pressed)
        else $error("swipe or double tap reported as pressed");

    // touch history follows the poll that moved through
    a_touch_history: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> was_touching_reg == $past(in_touch_reg))
        else $error("touch history not updated from processed poll");

    // a held poll is never dropped from the input stage
    a_no_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg)
        else $error("input stage lost a poll");

    // a single tap is only resolved while a tap was pending
    a_single_needs_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && tapped_next |-> tap_pending_reg && !was_touching_reg)
        else $error("single tap without pending tap");
`endif

endmodule

>>> verif/tb_touch_gesture_classifier.sv
`timescale 1ns / 1ps

module tb_touch_gesture_classifier;

    localparam int COORD_MAX    = (1 << tgc_pkg::COORD_W) - 1;
    localparam int RANDOM_POLLS = 1650;
    localparam int PHASES       = 6;

    typedef struct packed {
        logic [7:0]                    finger_count;
        logic [tgc_pkg::COORD_W-1:0]   raw_x;
        logic [tgc_pkg::COORD_W-1:0]   raw_y;
        logic [tgc_pkg::TIME_IN_W-1:0] time_ms;
    } touch_poll_t;

    typedef struct packed {
        tgc_pkg::gesture_t                  gesture;
        logic signed [tgc_pkg::POINT_W-1:0] point_x;
        logic [tgc_pkg::COORD_W-1:0]        point_y;
        logic                               pressed;
        logic                               tapped;
    } gesture_report_t;

    class gesture_scoreboard;
        logic [tgc_pkg::COORD_W-1:0]        mirror_offset, swipe_thresh, tap_move_limit;
        logic [tgc_pkg::DUR_W-1:0]          tap_hold_limit, pair_window;
        bit                                 was_touching, tap_pending;
        logic signed [tgc_pkg::POINT_W-1:0] start_x, last_x;
        logic [tgc_pkg::COORD_W-1:0]        start_y, last_y;
        logic [tgc_pkg::TIME_BITS-1:0]      touch_start_time, last_tap_time;
        gesture_report_t                    due_reports[$];
        int unsigned                        mismatches, reports_checked;
        int unsigned                        gesture_hits[7];

        function new();
            mirror_offset    = tgc_pkg::MIRROR_OFFSET_RST;
            swipe_thresh     = tgc_pkg::SWIPE_THRESH_RST;
            tap_move_limit   = tgc_pkg::TAP_MOVE_LIMIT_RST;
            tap_hold_limit   = tgc_pkg::TAP_HOLD_LIMIT_RST;
            pair_window      = tgc_pkg::PAIR_WINDOW_RST;
            was_touching     = 1'b0;
            tap_pending      = 1'b0;
            start_x          = '0;
            start_y          = '0;
            last_x           = '0;
            last_y           = '0;
            touch_start_time = '0;
            last_tap_time    = '0;
            mismatches       = 0;
            reports_checked  = 0;
            foreach (gesture_hits[i]) gesture_hits[i] = 0;
        endfunction

        function void write_reg(logic [tgc_pkg::CFG_INDEX_W-1:0] idx,
                                logic [tgc_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                tgc_pkg::REG_MIRROR_OFFSET:  mirror_offset  = data[tgc_pkg::COORD_W-1:0];
                tgc_pkg::REG_SWIPE_THRESH:   swipe_thresh   = data[tgc_pkg::COORD_W-1:0];
                tgc_pkg::REG_TAP_MOVE_LIMIT: tap_move_limit = data[tgc_pkg::COORD_W-1:0];
                tgc_pkg::REG_TAP_HOLD_LIMIT: tap_hold_limit = data[tgc_pkg::DUR_W-1:0];
                tgc_pkg::REG_PAIR_WINDOW:    pair_window    = data[tgc_pkg::DUR_W-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return due_reports.size();
        endfunction

        // classify one accepted poll and queue the report it must produce
        function void note_poll(touch_poll_t p);
            gesture_report_t                    r;
            bit                                 touching;
            logic [tgc_pkg::TIME_BITS-1:0]      held, since_tap;
            logic signed [tgc_pkg::DELTA_W-1:0] dx, dy;
            logic [tgc_pkg::DELTA_W-1:0]        adx, ady;
            touching  = (p.finger_count != '0);
            r.gesture = tgc_pkg::G_NONE;
            r.tapped  = 1'b0;
            if (touching) begin
                last_x    = $signed({1'b0, mirror_offset}) - $signed({1'b0, p.raw_x});
                last_y    = p.raw_y;
                r.pressed = 1'b1;
                if (!was_touching) begin
                    start_x          = last_x;
                    start_y          = last_y;
                    touch_start_time = p.time_ms;
                end
            end else begin
                r.pressed = 1'b0;
                if (was_touching) begin
                    held      = p.time_ms - touch_start_time;
                    since_tap = p.time_ms - last_tap_time;
                    dx        = last_x - start_x;
                    dy        = $signed({2'b00, last_y}) - $signed({2'b00, start_y});
                    adx       = (dx < 0) ? -dx : dx;
                    ady       = (dy < 0) ? -dy : dy;
                    if (adx > swipe_thresh && adx > ady) begin
                        r.gesture   = (dx > 0) ? tgc_pkg::G_RIGHT : tgc_pkg::G_LEFT;
                        tap_pending = 1'b0;
                    end else if (ady > swipe_thresh && ady > adx) begin
                        r.gesture   = (dy > 0) ? tgc_pkg::G_DOWN : tgc_pkg::G_UP;
                        tap_pending = 1'b0;
                    end else if (held < tap_hold_limit && adx < tap_move_limit
                                 && ady < tap_move_limit) begin
                        if (tap_pending && since_tap < pair_window) begin
                            r.gesture   = tgc_pkg::G_DOUBLE;
                            tap_pending = 1'b0;
                        end else begin
                            // first tap of a possible pair shows at the touch-down point
                            tap_pending   = 1'b1;
                            last_tap_time = p.time_ms;
                            last_x        = start_x;
                            last_y        = start_y;
                            r.pressed     = 1'b1;
                        end
                    end
                end
            end
            since_tap = p.time_ms - last_tap_time;
            if (tap_pending && !touching && !was_touching && since_tap >= pair_window)
            begin
                r.gesture   = tgc_pkg::G_SINGLE;
                r.tapped    = 1'b1;
                tap_pending = 1'b0;
                last_x      = start_x;
                last_y      = start_y;
                r.pressed   = 1'b1;
            end
            was_touching = touching;
            r.point_x    = last_x;
            r.point_y    = last_y;
            due_reports.push_back(r);
        endfunction

        function void check_report(gesture_report_t got);
            gesture_report_t want;
            if (due_reports.size() == 0) begin
                $error("report with no poll outstanding: gesture %0d", got.gesture);
                mismatches++;
                return;
            end
            want = due_reports.pop_front();
            reports_checked++;
            gesture_hits[int'(want.gesture)]++;
            if (got.gesture !== want.gesture) begin
                $error("gesture: expected %0d, got %0d", want.gesture, got.gesture);
                mismatches++;
            end
            if (got.point_x !== want.point_x) begin
                $error("point_x: expected %0d, got %0d", want.point_x, got.point_x);
                mismatches++;
            end
            if (got.point_y !== want.point_y) begin
                $error("point_y: expected %0d, got %0d", want.point_y, got.point_y);
                mismatches++;
            end
            if (got.pressed !== want.pressed) begin
                $error("pressed: expected %0b, got %0b", want.pressed, got.pressed);
                mismatches++;
            end
            if (got.tapped !== want.tapped) begin
                $error("tapped: expected %0b, got %0b", want.tapped, got.tapped);
                mismatches++;
            end
        endfunction
    endclass

    logic                               aclk           = 1'b0;
    logic                               aresetn        = 1'b0;
    logic                               cfg_wr_en      = 1'b0;
    logic [tgc_pkg::CFG_INDEX_W-1:0]    cfg_index      = '0;
    logic [tgc_pkg::CFG_DATA_W-1:0]     cfg_wdata      = '0;
    logic                               s_valid        = 1'b0;
    logic                               s_ready;
    logic [7:0]                         s_finger_count = '0;
    logic [tgc_pkg::COORD_W-1:0]        s_raw_x        = '0;
    logic [tgc_pkg::COORD_W-1:0]        s_raw_y        = '0;
    logic [tgc_pkg::TIME_IN_W-1:0]      s_time_ms      = '0;
    logic                               m_valid;
    logic                               m_ready        = 1'b0;
    logic [2:0]                         m_gesture;
    logic signed [tgc_pkg::POINT_W-1:0] m_point_x;
    logic [tgc_pkg::COORD_W-1:0]        m_point_y;
    logic                               m_pressed;
    logic                               m_tapped;

    gesture_scoreboard             sb;
    int unsigned                   send_idle_pct = 0;
    int unsigned                   recv_idle_pct = 0;
    int unsigned                   polls_sent    = 0;
    int unsigned                   cfg_writes    = 0;
    logic [tgc_pkg::TIME_IN_W-1:0] now_ms        = '0;

    touch_gesture_classifier i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_finger_count (s_finger_count),
        .s_raw_x        (s_raw_x),
        .s_raw_y        (s_raw_y),
        .s_time_ms      (s_time_ms),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_gesture      (m_gesture),
        .m_point_x      (m_point_x),
        .m_point_y      (m_point_y),
        .m_pressed      (m_pressed),
        .m_tapped       (m_tapped)
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin : collect_reports
        gesture_report_t got;
        if (m_valid && m_ready) begin
            got.gesture = tgc_pkg::gesture_t'(m_gesture);
            got.point_x = m_point_x;
            got.point_y = m_point_y;
            got.pressed = m_pressed;
            got.tapped  = m_tapped;
            sb.check_report(got);
        end
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic logic [tgc_pkg::COORD_W-1:0] clamp_coord(int v);
        if (v < 0) return '0;
        if (v > COORD_MAX) return tgc_pkg::COORD_W'(COORD_MAX);
        return tgc_pkg::COORD_W'(v);
    endfunction

    // uniform in [-lim, lim]
    function automatic int spread(int lim);
        return int'($urandom_range(2 * lim)) - lim;
    endfunction

    function automatic logic [7:0] fingers_down();
        return 8'($urandom_range(1, 255));
    endfunction

    function automatic logic [tgc_pkg::TIME_IN_W-1:0] pause_ms();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 60) return $urandom_range(1, 60);
        if (pick < 85) return $urandom_range(61, 1000);
        if (pick < 97) return $urandom_range(1001, 140000);
        return $urandom;
    endfunction

    // mostly keeps the whole touch under the tap time limit
    function automatic logic [tgc_pkg::TIME_IN_W-1:0] tap_step(int touches);
        int budget;
        budget = int'(sb.tap_hold_limit) / (touches + 1);
        if (budget < 1) budget = 1;
        if ($urandom_range(9) == 0) return pause_ms();
        return $urandom_range(1, budget);
    endfunction

    task automatic send_poll(input logic [7:0] fc, input logic [tgc_pkg::COORD_W-1:0] rx,
                             input logic [tgc_pkg::COORD_W-1:0] ry,
                             input logic [tgc_pkg::TIME_IN_W-1:0] dt);
        touch_poll_t p;
        now_ms         = now_ms + dt;
        p.finger_count = fc;
        p.raw_x        = rx;
        p.raw_y        = ry;
        p.time_ms      = now_ms;
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid        <= 1'b1;
        s_finger_count <= fc;
        s_raw_x        <= rx;
        s_raw_y        <= ry;
        s_time_ms      <= now_ms;
        do @(posedge aclk); while (!s_ready);
        sb.note_poll(p);
        polls_sent++;
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [tgc_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [tgc_pkg::CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        sb.write_reg(idx, data);
        cfg_writes++;
    endtask

    // unused upper data bits are randomized, they must be dropped
    task automatic set_thresholds(input logic [tgc_pkg::COORD_W-1:0] mirror,
                                  input logic [tgc_pkg::COORD_W-1:0] swipe,
                                  input logic [tgc_pkg::COORD_W-1:0] tap_dist,
                                  input logic [tgc_pkg::DUR_W-1:0] tap_ms,
                                  input logic [tgc_pkg::DUR_W-1:0] window_ms);
        cfg_write(tgc_pkg::REG_MIRROR_OFFSET, {4'($urandom), mirror});
        cfg_write(tgc_pkg::REG_SWIPE_THRESH, {4'($urandom), swipe});
        cfg_write(tgc_pkg::REG_TAP_MOVE_LIMIT, {4'($urandom), tap_dist});
        cfg_write(tgc_pkg::REG_TAP_HOLD_LIMIT, tap_ms);
        cfg_write(tgc_pkg::REG_PAIR_WINDOW, window_ms);
        // index past the register map must be ignored
        cfg_write(tgc_pkg::REG_PAIR_WINDOW
                  + tgc_pkg::CFG_INDEX_W'(1 + $urandom_range(250)),
                  tgc_pkg::CFG_DATA_W'($urandom));
        cfg_wr_en <= 1'b0;
    endtask

    task automatic random_tap();
        int touches, x0, y0, lim;
        touches = $urandom_range(1, 3);
        x0      = $urandom_range(COORD_MAX);
        y0      = $urandom_range(COORD_MAX);
        lim     = int'(sb.tap_move_limit) - 1;
        if (lim < 0) lim = 0;
        if (lim > 40) lim = 40;
        send_poll(fingers_down(), clamp_coord(x0), clamp_coord(y0), pause_ms());
        repeat (touches - 1)
            send_poll(fingers_down(), clamp_coord(x0 + spread(lim)),
                      clamp_coord(y0 + spread(lim)), tap_step(touches));
        send_poll('0, tgc_pkg::COORD_W'($urandom), tgc_pkg::COORD_W'($urandom),
                  tap_step(touches));
    endtask

    task automatic random_swipe();
        int touches, x0, y0, reach, across, ex, ey, k;
        touches = $urandom_range(2, 4);
        reach   = int'(sb.swipe_thresh) + int'($urandom_range(1, 300));
        across  = spread(reach / 2);
        if ($urandom_range(1)) reach = -reach;
        x0 = $urandom_range(COORD_MAX);
        y0 = $urandom_range(COORD_MAX);
        if ($urandom_range(1)) begin
            ex = x0 + reach;
            ey = y0 + across;
        end else begin
            ex = x0 + across;
            ey = y0 + reach;
        end
        for (k = 0; k < touches; k++)
            send_poll(fingers_down(), clamp_coord(x0 + (ex - x0) * k / (touches - 1)),
                      clamp_coord(y0 + (ey - y0) * k / (touches - 1)),
                      (k == 0) ? pause_ms() : tgc_pkg::TIME_IN_W'($urandom_range(1, 80)));
        send_poll('0, tgc_pkg::COORD_W'($urandom), tgc_pkg::COORD_W'($urandom),
                  $urandom_range(1, 200));
    endtask

    task automatic random_scribble();
        repeat ($urandom_range(1, 5))
            send_poll(fingers_down(), tgc_pkg::COORD_W'($urandom),
                      tgc_pkg::COORD_W'($urandom), $urandom_range(1, 300));
        send_poll('0, tgc_pkg::COORD_W'($urandom), tgc_pkg::COORD_W'($urandom), pause_ms());
    endtask

    task automatic random_noise();
        repeat ($urandom_range(1, 4))
            send_poll($urandom_range(1) ? 8'($urandom) : 8'd0, tgc_pkg::COORD_W'($urandom),
                      tgc_pkg::COORD_W'($urandom), pause_ms());
    endtask

    task automatic random_gesture();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 40) random_tap();
        else if (pick < 70) random_swipe();
        else if (pick < 85) random_scribble();
        else random_noise();
        // idle polls straddle the double tap window
        repeat ($urandom_range(2))
            send_poll('0, tgc_pkg::COORD_W'($urandom), tgc_pkg::COORD_W'($urandom),
                      $urandom_range(1) ? pause_ms()
                      : tgc_pkg::TIME_IN_W'($urandom_range(int'(sb.pair_window))));
    endtask

    initial begin
        int unsigned phase_end;
        sb = new();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // idle poll after reset reads back a zero point
        send_poll('0, 12'hFFF, 12'hFFF, 32'd10);
        // small nudge: first tap, reported at the touch-down point
        send_poll(8'd1, 12'd100, 12'd100, 32'd10);
        send_poll(8'd1, 12'd105, 12'd97, 32'd20);
        send_poll('0, '0, '0, 32'd20);
        // left swipe also drops the pending tap
        send_poll(8'd2, 12'd100, 12'd500, 32'd10);
        send_poll(8'd2, 12'd200, 12'd505, 32'd10);
        send_poll('0, '0, '0, 32'd10);
        send_poll(8'd3, 12'd300, 12'd500, 32'd10);
        send_poll(8'd3, 12'd150, 12'd495, 32'd10);
        send_poll('0, '0, '0, 32'd10);
        send_poll(8'd4, 12'd600, 12'd900, 32'd10);
        send_poll(8'd4, 12'd610, 12'd800, 32'd10);
        send_poll('0, '0, '0, 32'd10);
        send_poll(8'd5, 12'd600, 12'd800, 32'd10);
        send_poll(8'd5, 12'd590, 12'd1000, 32'd10);
        send_poll('0, '0, '0, 32'd10);
        // tap, then a corner-to-corner drag with equal axes: neither swipe nor tap
        send_poll(8'd1, 12'd50, 12'd50, 32'd30);
        send_poll('0, '0, '0, 32'd30);
        send_poll(8'hFF, '0, '0, 32'd10);
        send_poll(8'h80, 12'hFFF, 12'hFFF, 32'd10);
        send_poll('0, '0, '0, 32'd10);
        // tap still pending after the drag, so this is a double tap
        send_poll(8'd1, 12'd60, 12'd60, 32'd10);
        send_poll('0, '0, '0, 32'd10);
        // tap across the timestamp wrap, then idle until the window closes
        now_ms = 32'hFFFF_FFF5;
        send_poll(8'd1, 12'hFFF, '0, 32'd10);
        send_poll('0, '0, '0, 32'd17);
        send_poll('0, '0, '0, 32'd349);
        send_poll('0, '0, '0, 32'd1);

        for (int ph = 0; ph < PHASES; ph++) begin
            drain_results();
            case (ph)
                1: set_thresholds(12'hFFF, 12'hFFF, 12'hFFF, 16'hFFFF, 16'hFFFF);
                2: set_thresholds('0, '0, '0, '0, '0);
                3: set_thresholds('0, '0, 12'hFFF, 16'hFFFF, '0);
                4, 5: set_thresholds(tgc_pkg::COORD_W'($urandom),
                                     tgc_pkg::COORD_W'($urandom_range(5, 200)),
                                     tgc_pkg::COORD_W'($urandom_range(3, 60)),
                                     tgc_pkg::DUR_W'($urandom_range(50, 900)),
                                     tgc_pkg::DUR_W'($urandom_range(50, 900)));
                default: ;
            endcase
            if (ph < 2) begin
                send_idle_pct = 6;
                recv_idle_pct = 57;
            end else if (ph < 4) begin
                send_idle_pct = 57;
                recv_idle_pct = 6;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            phase_end = polls_sent + RANDOM_POLLS / PHASES;
            while (polls_sent < phase_end) random_gesture();
        end

        drain_results();
        repeat (4) @(posedge aclk);
        $display("run covered %0d polls, %0d reports checked, %0d register writes",
                 polls_sent, sb.reports_checked, cfg_writes);
        $display("reports: none %0d, swipes %0d, single taps %0d, double taps %0d",
                 sb.gesture_hits[tgc_pkg::G_NONE],
                 sb.gesture_hits[tgc_pkg::G_LEFT] + sb.gesture_hits[tgc_pkg::G_RIGHT]
                 + sb.gesture_hits[tgc_pkg::G_UP] + sb.gesture_hits[tgc_pkg::G_DOWN],
                 sb.gesture_hits[tgc_pkg::G_SINGLE], sb.gesture_hits[tgc_pkg::G_DOUBLE]);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("tb: success");
        end else begin
            if (sb.pending() != 0) $error("%0d reports never arrived", sb.pending());
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

>>> sim.f
design/tgc_pkg.sv
design/touch_gesture_classifier.sv
verif/tb_touch_gesture_classifier.sv
